/* rtl/bmg_pkg.sv */
// Shared types, constants and helper functions of the Gaussian noise generator.
package bmg_pkg;

    // Field widths of the request and the result.
    localparam int SIGMA_W  = 20;
    localparam int SAMPLE_W = 25;
    localparam int KW       = 53;

    // Generator reset value and arithmetic constants.
    localparam logic [63:0] SEED_RESET  = 64'h00C0_FFEE_1234_5678;
    localparam logic [52:0] U1_MIN      = 53'd9008;
    localparam logic [24:0] TWO_LN2_Q24 = 25'd23258160;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [32:0] GAIN_Q30    = 33'd652032874;
    localparam logic [37:0] LOG_TOP     = {6'd53, 32'd0};

    // One queued job: request plus the two uniforms drawn for it.
    typedef struct packed {
        logic [SIGMA_W-1:0] sigma;
        logic [KW-1:0]      k1;
        logic [31:0]        phase;
    } job_t;

    // One xorshift64 step with shifts 13, 7 and 17.
    function automatic logic [63:0] xs_next(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 7);
        return b ^ (b << 17);
    endfunction

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic [30:0] atan_q30(input logic [4:0] i);
        logic [30:0] r;
        unique case (i)
            5'd0:    r = 31'd843314857;
            5'd1:    r = 31'd497837829;
            5'd2:    r = 31'd263043837;
            5'd3:    r = 31'd133525159;
            5'd4:    r = 31'd67021687;
            5'd5:    r = 31'd33543516;
            5'd6:    r = 31'd16775851;
            5'd7:    r = 31'd8388437;
            5'd8:    r = 31'd4194283;
            5'd9:    r = 31'd2097149;
            default: r = 31'd1 << (5'd30 - i);
        endcase
        return r;
    endfunction

endpackage

/* rtl/bmg_fifo.sv */
// Short queue of jobs between the front and the back part.
module bmg_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bmg_pkg::job_t push_data,
    input  logic          pop,
    output bmg_pkg::job_t pop_data,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bmg_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/bmg_front.sv */
// Front part: register port, xorshift source and request acceptance.
module bmg_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bmg_pkg::SIGMA_W-1:0]  sigma,
    output logic                         q_push,
    output bmg_pkg::job_t                q_job,
    input  logic                         q_full
);

    logic [63:0] seed_reg;
    logic [63:0] state_reg;
    logic [63:0] x1;
    logic [63:0] x2;
    logic        seed_wr;

    assign seed_wr  = psel && penable && pwrite && !paddr[3];
    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;
    assign prdata   = paddr[3] ? 64'd0 : seed_reg;

    // Two generator steps per item, and the uniforms taken from them.
    always_comb
    begin
        x1          = bmg_pkg::xs_next(state_reg);
        x2          = bmg_pkg::xs_next(x1);
        q_job.sigma = sigma;
        q_job.k1    = (x1[63:11] < bmg_pkg::U1_MIN) ? bmg_pkg::U1_MIN : x1[63:11];
        q_job.phase = x2[63:32];
    end

    // Seed register and generator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= bmg_pkg::SEED_RESET;
            state_reg <= bmg_pkg::SEED_RESET;
        end
        else if (seed_wr)
        begin
            seed_reg  <= pwdata;
            state_reg <= pwdata;
        end
        else if (q_push)
        begin
            state_reg <= x2;
        end
    end

endmodule

/* rtl/bmg_back.sv */
// Back part: sequencer for log, square root, CORDIC cosine and scaling.
module bmg_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_empty,
    input  bmg_pkg::job_t                        q_job,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [bmg_pkg::SAMPLE_W-1:0]  sample
);

    localparam int          SH  = 54 - FRAC_BITS;
    localparam logic [63:0] RND = 64'd1 << (53 - FRAC_BITS);
    localparam logic [63:0] POS_MAX = 64'd16777215;
    localparam logic [63:0] NEG_MAG = 64'd16777216;

    typedef enum logic [3:0] {
        ST_IDLE, ST_NORM, ST_LOG, ST_R2, ST_SQI, ST_SQRT,
        ST_ZMUL, ST_CORDIC, ST_TMUL, ST_MMUL, ST_OUT
    } state_t;

    state_t                                state_reg;
    logic [bmg_pkg::SIGMA_W-1:0]           sigma_reg;
    logic [bmg_pkg::KW-1:0]                k_reg;
    logic [31:0]                           phase_reg;
    logic [5:0]                            e_reg;
    logic [31:0]                           m_reg;
    logic [31:0]                           frac_reg;
    logic [5:0]                            cnt_reg;
    logic [63:0]                           prod_reg;
    logic [61:0]                           n_reg;
    logic [62:0]                           res_reg;
    logic [62:0]                           bit_reg;
    logic signed [32:0]                    x_reg;
    logic signed [32:0]                    y_reg;
    logic signed [33:0]                    z_reg;
    logic [31:0]                           cmag_reg;
    logic                                  neg_reg;
    logic [30:0]                           t_reg;
    logic                                  out_valid_reg;
    logic signed [bmg_pkg::SAMPLE_W-1:0]   sample_reg;

    logic [63:0]        sq;
    logic [37:0]        d;
    logic [62:0]        trial;
    logic signed [32:0] xs;
    logic signed [32:0] ys;
    logic signed [33:0] at;
    logic signed [32:0] c;
    logic [63:0]        mag;
    logic               out_free;

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Datapath terms for the current step.
    always_comb
    begin
        sq    = m_reg * m_reg;
        d     = bmg_pkg::LOG_TOP - {e_reg, frac_reg};
        trial = res_reg + bit_reg;
        xs    = x_reg >>> cnt_reg[4:0];
        ys    = y_reg >>> cnt_reg[4:0];
        at    = {3'b000, bmg_pkg::atan_q30(cnt_reg[4:0])};
        unique case (phase_reg[31:30])
            2'd0:    c = x_reg;
            2'd1:    c = -y_reg;
            2'd2:    c = -x_reg;
            default: c = y_reg;
        endcase
        mag = (prod_reg + RND) >> SH;
    end

    // Sequencer with its working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // In the output state the valid flag is handled there alone.
            if (out_valid_reg && out_ready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        sigma_reg <= q_job.sigma;
                        k_reg     <= q_job.k1;
                        phase_reg <= q_job.phase;
                        e_reg     <= 6'd52;
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    if (k_reg[52])
                    begin
                        m_reg     <= k_reg[52:21];
                        frac_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_LOG;
                    end
                    else
                    begin
                        k_reg <= k_reg << 1;
                        e_reg <= e_reg - 1'b1;
                    end
                end
                ST_LOG:
                begin
                    if (sq[63])
                    begin
                        m_reg <= sq[63:32];
                    end
                    else
                    begin
                        m_reg <= sq[62:31];
                    end
                    frac_reg <= {frac_reg[30:0], sq[63]};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd31)
                    begin
                        state_reg <= ST_R2;
                    end
                end
                ST_R2:
                begin
                    prod_reg  <= 64'(d * bmg_pkg::TWO_LN2_Q24);
                    state_reg <= ST_SQI;
                end
                ST_SQI:
                begin
                    n_reg     <= {prod_reg[61:24], 24'd0};
                    res_reg   <= '0;
                    bit_reg   <= 63'd1 << 62;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    if ({1'b0, n_reg} >= trial)
                    begin
                        n_reg   <= 62'({1'b0, n_reg} - trial);
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg == 63'd1)
                    begin
                        state_reg <= ST_ZMUL;
                    end
                end
                ST_ZMUL:
                begin
                    z_reg     <= {3'b000, 31'((64'(phase_reg[29:0]) *
                                           64'(bmg_pkg::HALF_PI_Q30)) >> 30)};
                    x_reg     <= bmg_pkg::GAIN_Q30;
                    y_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_CORDIC;
                end
                ST_CORDIC:
                begin
                    if (!z_reg[33])
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - at;
                    end
                    else
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + at;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd29)
                    begin
                        state_reg <= ST_TMUL;
                    end
                end
                ST_TMUL:
                begin
                    neg_reg   <= c[32];
                    cmag_reg  <= c[32] ? 32'(-c) : c[31:0];
                    t_reg     <= 31'((64'(sigma_reg) * 64'(res_reg[30:0])) >> 20);
                    state_reg <= ST_MMUL;
                end
                ST_MMUL:
                begin
                    prod_reg  <= 64'(t_reg) * 64'(cmag_reg);
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        if (neg_reg)
                        begin
                            sample_reg <= (mag > NEG_MAG) ? {1'b1, 24'd0}
                                                          : 25'(~mag + 64'd1);
                        end
                        else
                        begin
                            sample_reg <= (mag > POS_MAX) ? 25'sd16777215 : 25'(mag);
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/box_muller_gaussian_noise_core.sv */
// Top level of the Box-Muller Gaussian noise generator.
// Each accepted item (a sigma in unsigned Q4.16) yields one signed sample with FRAC_BITS
// fractional bits, saturated to 25 bits; the seed register at byte address 0 reloads the
// xorshift64 state when written. The front part draws both uniforms at acceptance, so the
// input side accepts an item whenever the queue has room. The back part works one item at
// a time through a shared iterative datapath and takes no new job until it is back in idle:
// a normalizing shift of up to 39 bit positions, 32 log squaring steps, 32 square-root
// steps, 30 CORDIC rotations, the multiply states and an output state that can stall.
module box_muller_gaussian_noise_core #(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [3:0]                           paddr,
    input  logic [63:0]                          pwdata,
    output logic [63:0]                          prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [bmg_pkg::SIGMA_W-1:0]          sigma,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [bmg_pkg::SAMPLE_W-1:0]  sample
);

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    bmg_pkg::job_t push_job;
    bmg_pkg::job_t pop_job;

    assign pready = 1'b1;

    // Request side.
    bmg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sigma    (sigma),
        .q_push   (q_push),
        .q_job    (push_job),
        .q_full   (q_full)
    );

    // Job queue.
    bmg_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_job),
        .pop       (q_pop),
        .pop_data  (pop_job),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Math sequencer and output register.
    bmg_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (pop_job),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample)
    );

    // The back part never takes a job from an empty queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job taken from empty queue");

    // An item pushed without a pop leaves the queue non-empty.
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> !q_empty)
        else $error("accepted item missing from queue");

    // No item is pushed into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("push into a full queue");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the Box-Muller Gaussian noise generator.
module tb_top;

    localparam int FRAC = 16;
    localparam logic [3:0] ADDR_SEED = 4'd0;
    localparam logic [3:0] ADDR_UNUSED = 4'd8;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic pready;
    logic in_valid;
    logic in_ready;
    logic [bmg_pkg::SIGMA_W-1:0] sigma;
    logic out_valid;
    logic out_ready;
    logic signed [bmg_pkg::SAMPLE_W-1:0] sample;

    // Predictor state and expected samples.
    logic [63:0] gen_state;
    logic signed [bmg_pkg::SAMPLE_W-1:0] sample_q[$];
    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;

    box_muller_gaussian_noise_core #(.FRAC_BITS(FRAC)) u_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .sigma(sigma),
        .out_valid(out_valid), .out_ready(out_ready), .sample(sample)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One xorshift64 step of the predictor.
    function automatic logic [63:0] xorshift_step(input logic [63:0] x);
        logic [63:0] v;
        v = x;
        v = v ^ (v << 13);
        v = v ^ (v >> 7);
        v = v ^ (v << 17);
        return v;
    endfunction

    // Base-2 logarithm of k in Q32 by repeated squaring of the mantissa.
    function automatic logic [63:0] log2_fixed(input logic [63:0] k);
        int e;
        logic [63:0] m;
        logic [63:0] frac;
        logic [127:0] sq;
        e = 0;
        frac = 64'd0;
        while (e < 63 && (k >> (e + 1)) != 0)
            e++;
        if (e >= 31)
            m = k >> (e - 31);
        else
            m = k << (31 - e);
        for (int i = 0; i < 32; i++)
        begin
            sq = m * m;
            m = sq[63:0] >> 31;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                frac[31 - i] = 1'b1;
            end
        end
        return (64'(e) << 32) | frac;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bits;
        n = n_in;
        res = 64'd0;
        bits = 64'd1 << 62;
        while (bits > n)
            bits = bits >> 2;
        while (bits != 0)
        begin
            if (n >= res + bits)
            begin
                n = n - (res + bits);
                res = (res >> 1) + bits;
            end
            else
                res = res >> 1;
            bits = bits >> 2;
        end
        return res;
    endfunction

    // CORDIC cosine of a phase in Q32 turns, result in Q30.
    function automatic longint cordic_cos(input logic [31:0] phase);
        logic [1:0] quad;
        logic [63:0] f;
        longint z;
        longint x;
        longint y;
        longint nx;
        longint at;
        longint atans[10];
        atans = '{843314857, 497837829, 263043837, 133525159, 67021687,
                  33543516, 16775851, 8388437, 4194283, 2097149};
        quad = phase[31:30];
        f = {34'd0, phase[29:0]};
        z = longint'((f * 64'd1686629713) >> 30);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            at = (i < 10) ? atans[i] : (longint'(1) <<< (30 - i));
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - at;
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + at;
            end
            x = nx;
        end
        case (quad)
            2'd0: return x;
            2'd1: return -y;
            2'd2: return -x;
            default: return y;
        endcase
    endfunction

    // Predicts the sample for one sigma and advances the generator.
    function automatic logic signed [bmg_pkg::SAMPLE_W-1:0] predict_sample(
        input logic [19:0] sg);
        logic [63:0] k1;
        logic [63:0] k2;
        logic [63:0] d;
        logic [63:0] r2;
        logic [63:0] radius;
        logic [63:0] t;
        logic [63:0] cmag;
        logic [63:0] mag;
        logic [127:0] wide;
        longint c;
        gen_state = xorshift_step(gen_state);
        k1 = gen_state >> 11;
        gen_state = xorshift_step(gen_state);
        k2 = gen_state >> 11;
        if (k1 < 64'd9008)
            k1 = 64'd9008;
        d = (64'd53 << 32) - log2_fixed(k1);
        wide = d * 64'd23258160;
        r2 = wide[63:0] >> 24;
        radius = int_sqrt(r2 << 24);
        c = cordic_cos(k2[52:21]);
        cmag = (c < 0) ? 64'(-c) : 64'(c);
        wide = {44'd0, sg} * radius;
        t = wide[63:0] >> 20;
        wide = t * cmag;
        mag = (wide[63:0] + (64'd1 << (53 - FRAC))) >> (54 - FRAC);
        if (c < 0)
        begin
            if (mag > 64'd16777216)
                mag = 64'd16777216;
            return bmg_pkg::SAMPLE_W'(~mag + 64'd1);
        end
        if (mag > 64'd16777215)
            mag = 64'd16777215;
        return bmg_pkg::SAMPLE_W'(mag);
    endfunction

    // Register write over the APB port; only the seed affects the predictor.
    task automatic write_reg(input logic [3:0] addr, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SEED)
            gen_state = value;
    endtask

    // Sends one item, with optional random idle cycles first.
    task automatic send_item(input logic [19:0] sg);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sigma <= sg;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sample_q.push_back(predict_sample(sg));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sample_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Random sigma: mostly full range, some small and some at the top.
    function automatic logic [19:0] rand_sigma();
        case ($urandom_range(3))
            0: return 20'($urandom_range(255));
            1: return 20'hFFFFF - 20'($urandom_range(15));
            default: return 20'($urandom);
        endcase
    endfunction

    // Extremes of sigma and both seed extremes, including a zero seed.
    task automatic test_directed();
        logic [19:0] vals[8];
        vals = '{20'd0, 20'd1, 20'hFFFFF, 20'h10000, 20'h80000, 20'h7FFFF,
                 20'h55555, 20'hAAAAA};
        foreach (vals[i]) send_item(vals[i]);
        wait_drained();
        write_reg(ADDR_SEED, 64'd1);
        for (int i = 0; i < 4; i++) send_item(20'hFFFFF);
        wait_drained();
        write_reg(ADDR_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 4; i++) send_item(vals[i]);
        wait_drained();
        // A zero seed pins the first uniform at its clamped minimum.
        write_reg(ADDR_SEED, 64'd0);
        for (int i = 0; i < 3; i++) send_item(20'hFFFFF);
        wait_drained();
        write_reg(ADDR_UNUSED, 64'h1234);
        send_item(20'h12345);
        wait_drained();
    endtask

    // Random phase with a given idle mix and a fresh seed.
    task automatic test_random(input int s_pct, input int r_pct, input int count);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        write_reg(ADDR_SEED, {$urandom, $urandom} | 64'd1);
        for (int i = 0; i < count; i++)
        begin
            send_item(rand_sigma());
            // Hold off until the block has drained, once per phase.
            if (i == count / 2)
            begin
                in_valid <= 1'b0;
                while (sample_q.size() != 0)
                    @(posedge clk);
            end
        end
        wait_drained();
    endtask

    // Receiver stall and result checking.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (sample_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected sample %0d", sample);
                end
                else
                begin
                    if (sample !== sample_q[0])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Sample mismatch: expected %0d actual %0d",
                                     sample_q[0], sample);
                    end
                    void'(sample_q.pop_front());
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #40000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        mismatches = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_state = bmg_pkg::SEED_RESET;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 4'd0;
        pwdata = 64'd0;
        in_valid = 1'b0;
        sigma = '0;
        out_ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(11, 71, 480);
        test_random(71, 11, 480);
        test_random(0, 0, 480);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
